/* rtl/core/sobl_pkg.sv */
package sobl_pkg;

    // Command codes of an input request
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Configuration register indexes
    localparam logic [7:0] CFG_WINDOW_LEFT    = 8'd0;
    localparam logic [7:0] CFG_WINDOW_TOP     = 8'd1;
    localparam logic [7:0] CFG_OVERLAY_WIDTH  = 8'd2;
    localparam logic [7:0] CFG_OVERLAY_HEIGHT = 8'd3;
    localparam logic [7:0] CFG_SCALE_FACTOR   = 8'd4;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [7:0] ALPHA_MAX = 8'hFF;

    // Reciprocal fixed point: quotient = (d * recip) >> RECIP_SHIFT, exact for d < 4096
    localparam int RECIP_SHIFT = 17;
    localparam int RECIP_W     = 18;

    typedef struct packed {
        logic        cmd;
        logic [13:0] texel_addr;
        logic [11:0] pix_x;
        logic [11:0] pix_y;
        logic [7:0]  in_red;
        logic [7:0]  in_green;
        logic [7:0]  in_blue;
        logic [7:0]  in_alpha;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } out_item_t;

    // Classified request held in the queue between front and back
    typedef struct packed {
        logic        is_pix;
        logic        in_win;
        logic [11:0] dx;
        logic [11:0] dy;
        logic [13:0] addr;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } work_t;

    // Static settings the back part needs
    typedef struct packed {
        logic [8:0]         width;
        logic [RECIP_W-1:0] recip;
    } back_cfg_t;

    // ceil(2^17 / s); a zero scale behaves as one
    function automatic logic [RECIP_W-1:0] scale_recip(input logic [4:0] s);
        logic [RECIP_W-1:0] r;
        unique case (s)
            5'd0, 5'd1: r = 18'd131072;
            5'd2:  r = 18'd65536;
            5'd3:  r = 18'd43691;
            5'd4:  r = 18'd32768;
            5'd5:  r = 18'd26215;
            5'd6:  r = 18'd21846;
            5'd7:  r = 18'd18725;
            5'd8:  r = 18'd16384;
            5'd9:  r = 18'd14564;
            5'd10: r = 18'd13108;
            5'd11: r = 18'd11916;
            5'd12: r = 18'd10923;
            5'd13: r = 18'd10083;
            5'd14: r = 18'd9363;
            5'd15: r = 18'd8739;
            5'd16: r = 18'd8192;
            5'd17: r = 18'd7711;
            5'd18: r = 18'd7282;
            5'd19: r = 18'd6899;
            5'd20: r = 18'd6554;
            5'd21: r = 18'd6242;
            5'd22: r = 18'd5958;
            5'd23: r = 18'd5699;
            5'd24: r = 18'd5462;
            5'd25: r = 18'd5243;
            5'd26: r = 18'd5042;
            5'd27: r = 18'd4855;
            5'd28: r = 18'd4682;
            5'd29: r = 18'd4520;
            5'd30: r = 18'd4370;
            5'd31: r = 18'd4229;
        endcase
        return r;
    endfunction

    // v / 255 for v below 65280
    function automatic logic [7:0] div255(input logic [16:0] v);
        logic [16:0] sum;
        sum = v + (v >> 8) + 17'd1;
        return sum[15:8];
    endfunction

endpackage

/* rtl/core/sobl_ram.sv */
module sobl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

/* rtl/core/sobl_front.sv */
module sobl_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [sobl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sobl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    input  sobl_pkg::in_item_t                  in_data,
    input  logic                                q_full,
    output logic                                push,
    output sobl_pkg::work_t                     push_data,
    output sobl_pkg::back_cfg_t                 back_cfg
);

    logic [11:0] left_reg;
    logic [11:0] top_reg;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [4:0]  scale_reg;

    logic [4:0]  s_eff;
    logic [13:0] win_w;
    logic [13:0] win_h;
    logic [14:0] right_x;
    logic [14:0] bottom_y;
    logic        in_win;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            scale_reg  <= 5'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sobl_pkg::CFG_WINDOW_LEFT:    left_reg   <= cfg_data[11:0];
                sobl_pkg::CFG_WINDOW_TOP:     top_reg    <= cfg_data[11:0];
                sobl_pkg::CFG_OVERLAY_WIDTH:  width_reg  <= cfg_data[8:0];
                sobl_pkg::CFG_OVERLAY_HEIGHT: height_reg <= cfg_data[8:0];
                sobl_pkg::CFG_SCALE_FACTOR:   scale_reg  <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        s_eff    = (scale_reg == 5'd0) ? 5'd1 : scale_reg;
        win_w    = 14'(width_reg) * 14'(s_eff);
        win_h    = 14'(height_reg) * 14'(s_eff);
        right_x  = 15'(left_reg) + 15'(win_w);
        bottom_y = 15'(top_reg) + 15'(win_h);
        in_win   = (in_data.pix_x >= left_reg) && (15'(in_data.pix_x) < right_x) &&
                   (in_data.pix_y >= top_reg) && (15'(in_data.pix_y) < bottom_y);

        push                = in_valid && !q_full;
        push_data.is_pix    = (in_data.cmd == sobl_pkg::CMD_PIXEL);
        push_data.in_win    = in_win;
        push_data.dx        = in_data.pix_x - left_reg;
        push_data.dy        = in_data.pix_y - top_reg;
        push_data.addr      = in_data.texel_addr;
        push_data.red       = in_data.in_red;
        push_data.green     = in_data.in_green;
        push_data.blue      = in_data.in_blue;
        push_data.alpha     = in_data.in_alpha;

        back_cfg.width = width_reg;
        back_cfg.recip = sobl_pkg::scale_recip(scale_reg);
    end

endmodule

/* rtl/core/sobl_queue.sv */
module sobl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sobl_pkg::work_t push_data,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output sobl_pkg::work_t head
);

    sobl_pkg::work_t slot_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;
    logic [2:0] count_next;

    assign full      = (count_reg == 3'd4);
    assign not_empty = (count_reg != 3'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + 3'(push) - 3'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/core/sobl_back.sv */
module sobl_back #(
    parameter int OVERLAY_DEPTH = 16384
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sobl_pkg::back_cfg_t back_cfg,
    input  logic                q_not_empty,
    input  sobl_pkg::work_t     q_head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output sobl_pkg::out_item_t out_data
);

    localparam int AW = $clog2(OVERLAY_DEPTH);

    logic adv;

    // stage 1: reciprocal products
    logic        v1_reg, pix1_reg, in1_reg;
    logic [29:0] px1_reg, py1_reg;
    logic [13:0] addr1_reg;
    logic [31:0] tex1_reg;

    // stage 2: row offset product
    logic        v2_reg, pix2_reg, in2_reg;
    logic [8:0]  qx2_reg;
    logic [17:0] pw2_reg;
    logic [13:0] addr2_reg;
    logic [31:0] tex2_reg;

    // stage 3: store access issued
    logic        v3_reg, blend3_reg;
    logic [23:0] rgb3_reg;

    // stage 4: blend products
    logic        v4_reg, blend4_reg;
    logic [23:0] rgb4_reg;
    logic [16:0] mix4_reg [3];

    logic        out_valid_reg;
    sobl_pkg::out_item_t out_data_reg;

    logic [31:0] idx_w;
    logic [31:0] laddr_w;
    logic        idx_ok;
    logic        load_ok;
    logic        ram_en;
    logic        ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0] ram_rdata;
    logic [7:0]  tex_a;
    logic [16:0] mix_next [3];

    assign adv       = !out_valid_reg || out_ready;
    assign pop       = adv && q_not_empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        idx_w    = 32'(pw2_reg) + 32'(qx2_reg);
        laddr_w  = 32'(addr2_reg);
        idx_ok   = idx_w < 32'(OVERLAY_DEPTH);
        load_ok  = laddr_w < 32'(OVERLAY_DEPTH);
        ram_en   = adv && v2_reg && (pix2_reg || load_ok);
        ram_we   = !pix2_reg;
        ram_addr = pix2_reg ? idx_w[AW-1:0] : laddr_w[AW-1:0];

        tex_a = ram_rdata[31:24];
        for (int c = 0; c < 3; c++)
        begin
            mix_next[c] = 17'(rgb3_reg[c*8 +: 8]) * 17'(sobl_pkg::ALPHA_MAX - tex_a)
                        + 17'(ram_rdata[c*8 +: 8]) * 17'(tex_a);
        end
    end

    sobl_ram #(
        .WIDTH (32),
        .DEPTH (OVERLAY_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (tex2_reg),
        .rdata (ram_rdata)
    );

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pix1_reg  <= q_head.is_pix;
            in1_reg   <= q_head.in_win;
            px1_reg   <= 30'(q_head.dx) * 30'(back_cfg.recip);
            py1_reg   <= 30'(q_head.dy) * 30'(back_cfg.recip);
            addr1_reg <= q_head.addr;
            tex1_reg  <= {q_head.alpha, q_head.blue, q_head.green, q_head.red};

            pix2_reg  <= pix1_reg;
            in2_reg   <= in1_reg;
            qx2_reg   <= px1_reg[sobl_pkg::RECIP_SHIFT +: 9];
            pw2_reg   <= 18'(back_cfg.width) * 18'(py1_reg[sobl_pkg::RECIP_SHIFT +: 9]);
            addr2_reg <= addr1_reg;
            tex2_reg  <= tex1_reg;

            blend3_reg <= in2_reg && idx_ok;
            rgb3_reg   <= tex2_reg[23:0];

            blend4_reg <= blend3_reg;
            rgb4_reg   <= rgb3_reg;
            for (int c = 0; c < 3; c++)
            begin
                mix4_reg[c] <= mix_next[c];
            end

            out_data_reg.out_red   <= blend4_reg ? sobl_pkg::div255(mix4_reg[0]) : rgb4_reg[7:0];
            out_data_reg.out_green <= blend4_reg ? sobl_pkg::div255(mix4_reg[1]) : rgb4_reg[15:8];
            out_data_reg.out_blue  <= blend4_reg ? sobl_pkg::div255(mix4_reg[2]) : rgb4_reg[23:16];
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= q_not_empty;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg && pix2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

endmodule

/* rtl/core/scaled_overlay_alpha_blend.sv */
// Channel   Direction  Handshake                 Payload
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data (register writes)
// in        in         in_valid  / in_ready      in_data  (load texel or blend pixel)
// out       out        out_valid / out_ready     out_data (blended or passed pixel)
//
// One request per clock enters and leaves while the output is not stalled; a pixel's
// result passes through the queue, two multiply stages, store read, blend multiply and
// the divide-by-255 output register. Load requests write the store at the same stage as
// pixel reads, so loads and reads keep request order; loads give no result.
// Reset clears configuration, queue and stage valids; the overlay store is not cleared.
// A stalled output holds every back stage; the four-entry queue absorbs the front.
module scaled_overlay_alpha_blend #(
    parameter int OVERLAY_DEPTH = 16384
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sobl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sobl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  sobl_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output sobl_pkg::out_item_t              out_data
);

    logic                q_full;
    logic                q_not_empty;
    logic                push;
    logic                pop;
    sobl_pkg::work_t     push_data;
    sobl_pkg::work_t     q_head;
    sobl_pkg::back_cfg_t back_cfg;

    // registers accept a write every cycle
    assign cfg_ready = 1'b1;
    // take a request whenever the queue has room
    assign in_ready  = !q_full;

    sobl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data),
        .back_cfg  (back_cfg)
    );

    sobl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    sobl_back #(
        .OVERLAY_DEPTH (OVERLAY_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .back_cfg    (back_cfg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

/* rtl/core/sobl_checker.sv */
module sobl_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_ready,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input sobl_pkg::out_item_t              out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    // after reset no result is valid and both inputs are ready
    a_reset_clean: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid && in_ready && cfg_ready)
        else $error("not clean after reset");

    // no result before the shortest path through the back part
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> ##4 !out_valid)
        else $error("result appeared too early after reset");

endmodule

bind scaled_overlay_alpha_blend sobl_checker u_sobl_checker (.*);

/* tb/tb_scaled_overlay_alpha_blend.sv */
`timescale 1ns / 1ps

module tb_scaled_overlay_alpha_blend;
    import sobl_pkg::*;

    localparam int DEPTH = 16384;
    // An index past the register list; writes to it are dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_NO_REG = 8'd7;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;

    scaled_overlay_alpha_blend #(.OVERLAY_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    // Shadow copy of the block's settings and overlay image
    logic [11:0] win_left;
    logic [11:0] win_top;
    logic [8:0] ovl_w;
    logic [8:0] ovl_h;
    logic [4:0] ovl_scale;
    logic [31:0] texels [DEPTH];
    bit texel_valid [DEPTH];

    out_item_t pending_pixels[$];
    int mismatches;
    int blend_hits;

    // One row of the directed table; a row with check set carries a typed-in result
    typedef struct {
        in_item_t req;
        bit check;
        out_item_t want;
    } dir_row_t;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [7:0] mix(input int p, input int t, input int a);
        return 8'((p * (255 - a) + t * a) / 255);
    endfunction

    // Work out the colour that a pixel request should come back with
    function automatic out_item_t blend_pixel(input in_item_t r);
        out_item_t o;
        int s;
        int idx;
        logic [31:0] tx;
        o = '{r.in_red, r.in_green, r.in_blue};
        s = (ovl_scale == 0) ? 1 : int'(ovl_scale);
        if (r.pix_x >= win_left && int'(r.pix_x) < int'(win_left) + int'(ovl_w) * s
            && r.pix_y >= win_top && int'(r.pix_y) < int'(win_top) + int'(ovl_h) * s)
        begin
            idx = (int'(r.pix_x) - int'(win_left)) / s
                + int'(ovl_w) * ((int'(r.pix_y) - int'(win_top)) / s);
            if (idx < DEPTH)
            begin
                tx = texels[idx];
                o.out_red = mix(r.in_red, tx[7:0], tx[31:24]);
                o.out_green = mix(r.in_green, tx[15:8], tx[31:24]);
                o.out_blue = mix(r.in_blue, tx[23:16], tx[31:24]);
            end
        end
        return o;
    endfunction

    // Index of the texel a pixel would read, or -1 where it reads none
    function automatic int texel_index(input logic [11:0] x, input logic [11:0] y);
        int s;
        int idx;
        s = (ovl_scale == 0) ? 1 : int'(ovl_scale);
        if (x >= win_left && int'(x) < int'(win_left) + int'(ovl_w) * s
            && y >= win_top && int'(y) < int'(win_top) + int'(ovl_h) * s)
        begin
            idx = (int'(x) - int'(win_left)) / s + int'(ovl_w) * ((int'(y) - int'(win_top)) / s);
            return (idx < DEPTH) ? idx : -1;
        end
        return -1;
    endfunction

    // Drop valid for a random gap, mostly short; a zero gap keeps valid high
    task automatic pause_random();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0)
            n = 0;
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Hand one request over; predict its result and keep the shadow store up to date
    task automatic send_request(input in_item_t r, input bit check, input out_item_t want);
        out_item_t exp_pix;
        in_valid <= 1'b1;
        in_data <= r;
        do @(posedge clk); while (!in_ready);
        if (r.cmd == CMD_LOAD)
        begin
            texels[r.texel_addr] = {r.in_alpha, r.in_blue, r.in_green, r.in_red};
            texel_valid[r.texel_addr] = 1'b1;
        end
        else
        begin
            exp_pix = check ? want : blend_pixel(r);
            pending_pixels.push_back(exp_pix);
            if (texel_index(r.pix_x, r.pix_y) >= 0)
                blend_hits++;
        end
        if ($urandom_range(0, 3) == 0)
            pause_random();
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_WINDOW_LEFT: win_left = 12'(value);
            CFG_WINDOW_TOP: win_top = 12'(value);
            CFG_OVERLAY_WIDTH: ovl_w = 9'(value);
            CFG_OVERLAY_HEIGHT: ovl_h = 9'(value);
            CFG_SCALE_FACTOR: ovl_scale = 5'(value);
            default: ;
        endcase
    endtask

    // Hold until every pixel is back, then let trailing loads clear the pipeline
    task automatic drain();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (pending_pixels.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        if (pending_pixels.size() != 0)
        begin
            $display("Some tests failed");
            $finish;
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic set_window(input int l, input int t, input int w, input int h, input int s);
        write_reg(CFG_WINDOW_LEFT, l);
        write_reg(CFG_WINDOW_TOP, t);
        write_reg(CFG_OVERLAY_WIDTH, w);
        write_reg(CFG_OVERLAY_HEIGHT, h);
        write_reg(CFG_SCALE_FACTOR, s);
    endtask

    function automatic in_item_t load_req(input int addr, input logic [31:0] rgba);
        in_item_t r;
        r = in_item_t'($urandom());
        r.cmd = CMD_LOAD;
        r.texel_addr = 14'(addr);
        {r.in_alpha, r.in_blue, r.in_green, r.in_red} = rgba;
        return r;
    endfunction

    function automatic in_item_t pix_req(input int x, input int y, input logic [23:0] rgb);
        in_item_t r;
        r = in_item_t'($urandom());
        r.cmd = CMD_PIXEL;
        r.pix_x = 12'(x);
        r.pix_y = 12'(y);
        {r.in_blue, r.in_green, r.in_red} = rgb;
        return r;
    endfunction

    // Fill texels 0 .. w*h-1 with random content so every in-window read hits a written entry
    task automatic fill_overlay(input int count);
        for (int i = 0; i < count; i++)
            send_request(load_req(i, $urandom()), 1'b0, '0);
    endtask

    // Random pixel, mostly in or near the window; pixels that would read an unwritten texel are moved
    function automatic in_item_t rand_pixel();
        in_item_t r;
        int s;
        int idx;
        s = (ovl_scale == 0) ? 1 : int'(ovl_scale);
        r = pix_req(0, 0, 24'($urandom()));
        if ($urandom_range(0, 4) != 0)
        begin
            r.pix_x = 12'(int'(win_left) + $urandom_range(0, int'(ovl_w) * s + 2) - 1);
            r.pix_y = 12'(int'(win_top) + $urandom_range(0, int'(ovl_h) * s + 2) - 1);
        end
        else
        begin
            r.pix_x = 12'($urandom());
            r.pix_y = 12'($urandom());
        end
        idx = texel_index(r.pix_x, r.pix_y);
        if (idx >= 0 && !texel_valid[idx])
            r.pix_x = 12'(int'(win_left) - 1);
        if (texel_index(r.pix_x, r.pix_y) >= 0 && !texel_valid[texel_index(r.pix_x, r.pix_y)])
            r.pix_y = 12'(int'(win_top) - 1);
        return r;
    endfunction

    // Check the results against the oldest expectation as they are taken
    always @(posedge clk)
    begin
        out_item_t exp_pix;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", out_data);
            end
            else
            begin
                exp_pix = pending_pixels.pop_front();
                if (out_data.out_red !== exp_pix.out_red
                    || out_data.out_green !== exp_pix.out_green
                    || out_data.out_blue !== exp_pix.out_blue)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: expected %h actual %h", exp_pix, out_data);
                end
            end
        end
    end

    // Stall the result side at random, with calm stretches
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if ($urandom_range(0, 299) < 3)
            out_ready <= 1'b0;
        else if (!out_ready)
            out_ready <= ($urandom_range(0, 9) < 3);
        else
            out_ready <= ($urandom_range(0, 9) != 0);
    end

    initial
    begin
        dir_row_t dir_rows[$];
        dir_row_t row;
        int w;
        int h;
        int s;
        mismatches = 0;
        blend_hits = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        win_left = '0;
        win_top = '0;
        ovl_w = '0;
        ovl_h = '0;
        ovl_scale = 5'd1;
        foreach (texel_valid[i])
            texel_valid[i] = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset the window is empty: pixels pass through untouched
        dir_rows.push_back('{pix_req(0, 0, 24'h000000), 1'b1, '{8'h00, 8'h00, 8'h00}});
        dir_rows.push_back('{pix_req(4095, 4095, 24'hFFFFFF), 1'b1, '{8'hFF, 8'hFF, 8'hFF}});
        // Load beyond the store size cannot occur with a 14-bit address at depth 16384;
        // the top address is written instead
        dir_rows.push_back('{load_req(16383, 32'hFF102030), 1'b0, '0});
        dir_rows.push_back('{load_req(0, 32'hFF0000FF), 1'b0, '0});
        dir_rows.push_back('{load_req(1, 32'h00FFFFFF), 1'b0, '0});
        dir_rows.push_back('{load_req(2, 32'h80FF00FF), 1'b0, '0});
        dir_rows.push_back('{load_req(3, 32'hFFFFFFFF), 1'b0, '0});
        foreach (dir_rows[i])
            send_request(dir_rows[i].req, dir_rows[i].check, dir_rows[i].want);
        drain();

        // Two by two overlay, scale zero behaves as one
        dir_rows.delete();
        set_window(10, 20, 2, 2, 0);
        // Opaque red texel replaces the pixel
        dir_rows.push_back('{pix_req(10, 20, 24'h123456), 1'b1, '{8'hFF, 8'h00, 8'h00}});
        // Transparent texel leaves the pixel
        dir_rows.push_back('{pix_req(11, 20, 24'h123456), 1'b1, '{8'h56, 8'h34, 8'h12}});
        dir_rows.push_back('{pix_req(10, 21, 24'h000000), 1'b0, '0});
        dir_rows.push_back('{pix_req(11, 21, 24'h000000), 1'b1, '{8'hFF, 8'hFF, 8'hFF}});
        // Just outside every edge
        dir_rows.push_back('{pix_req(9, 20, 24'hABCDEF), 1'b1, '{8'hEF, 8'hCD, 8'hAB}});
        dir_rows.push_back('{pix_req(12, 20, 24'hABCDEF), 1'b1, '{8'hEF, 8'hCD, 8'hAB}});
        dir_rows.push_back('{pix_req(10, 19, 24'hABCDEF), 1'b1, '{8'hEF, 8'hCD, 8'hAB}});
        dir_rows.push_back('{pix_req(10, 22, 24'hABCDEF), 1'b1, '{8'hEF, 8'hCD, 8'hAB}});
        foreach (dir_rows[i])
            send_request(dir_rows[i].req, dir_rows[i].check, dir_rows[i].want);
        drain();

        // A 256 by 256 overlay at scale 16 with its corner at the far pixel: reads texel 0
        dir_rows.delete();
        set_window(4095, 4095, 256, 256, 16);
        dir_rows.push_back('{pix_req(4095, 4095, 24'h00FF00), 1'b1, '{8'hFF, 8'h00, 8'h00}});
        foreach (dir_rows[i])
            send_request(dir_rows[i].req, dir_rows[i].check, dir_rows[i].want);
        drain();
        set_window(0, 0, 256, 256, 31);
        // Far row: index past the store passes through; top-left reads texel 0
        send_request(pix_req(0, 4095, 24'h112233), 1'b1, '{8'h33, 8'h22, 8'h11});
        send_request(pix_req(30, 30, 24'h112233), 1'b1, '{8'hFF, 8'h00, 8'h00});
        drain();

        // Random phases: well-formed overlay fill followed by pixel streams
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: begin w = 1; h = 1; s = 1; end
                1: begin w = 256; h = 1; s = 16; end
                2: begin w = 1; h = 256; s = 1; end
                default: begin w = $urandom_range(1, 8); h = $urandom_range(1, 8);
                               s = $urandom_range(1, 16); end
            endcase
            set_window($urandom_range(0, 4095), $urandom_range(0, 4095), w, h, s);
            if (phase == 5)
                write_reg(CFG_WINDOW_LEFT, 0);
            if (phase == 6)
                write_reg(CFG_WINDOW_TOP, 0);
            if (phase == 7)
                write_reg(CFG_NO_REG, $urandom());
            fill_overlay((w * h > 1024) ? 64 : w * h);
            for (int k = 0; k < 80; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_request(load_req($urandom_range(0, w * h - 1), $urandom()), 1'b0, '0);
                else
                    send_request(rand_pixel(), 1'b0, '0);
            end
            drain();
        end

        drain();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
